FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the planar arm kinematics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pafk_pkg.sv
// Types, constants and series tables of the planar arm kinematics block
package pafk_pkg;

    // defaults of the top-level parameters
    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // arm and port shape
    localparam int JOINTS    = 6;
    localparam int HOLD_BITS = 6;
    localparam int POS_BITS  = 16;

    // angle and fixed-point formats
    localparam int TURN_BITS = 32;
    localparam int OCT_BITS  = 29;
    localparam int Q_BITS    = 30;
    localparam int TRIG_BITS = 32;
    localparam logic [Q_BITS:0] Q30_ONE = (Q_BITS + 1)'(1) << Q_BITS;
    localparam logic [32:0]     PI_Q31  = 33'h1_921F_B544;

    // nested series: divisors and their floor reciprocals in 2^-32 units
    localparam int SIN_TERMS  = 5;
    localparam int COS_TERMS  = 6;
    localparam int DIV_BITS   = 8;
    localparam int RECIP_BITS = 32;
    localparam logic [63:0] RECIP_BASE = 64'd1 << RECIP_BITS;

    localparam logic [DIV_BITS-1:0] SIN_DIV [SIN_TERMS] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110
    };
    localparam logic [RECIP_BITS-1:0] SIN_RECIP [SIN_TERMS] = '{
        32'(RECIP_BASE / 64'd6),  32'(RECIP_BASE / 64'd20), 32'(RECIP_BASE / 64'd42),
        32'(RECIP_BASE / 64'd72), 32'(RECIP_BASE / 64'd110)
    };
    localparam logic [DIV_BITS-1:0] COS_DIV [COS_TERMS] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132
    };
    localparam logic [RECIP_BITS-1:0] COS_RECIP [COS_TERMS] = '{
        32'(RECIP_BASE / 64'd2),  32'(RECIP_BASE / 64'd12), 32'(RECIP_BASE / 64'd30),
        32'(RECIP_BASE / 64'd56), 32'(RECIP_BASE / 64'd90), 32'(RECIP_BASE / 64'd132)
    };

    // pipeline depths
    localparam int LANE_LAT  = 4 + 3 * COS_TERMS;
    localparam int MERGE_LAT = 3;

    typedef logic [Q_BITS-1:0]          t_q30;
    typedef logic [Q_BITS:0]            t_unit;
    typedef logic signed [TRIG_BITS-1:0] t_trig;
    typedef logic signed [POS_BITS-1:0]  t_pos;

    typedef struct packed {
        t_trig s;
        t_trig c;
    } t_sincos;

    typedef struct packed {
        t_pos x;
        t_pos y;
    } t_position;

endpackage

FILE: hdl/pafk_if.sv
// Valid/ready channel interfaces of the planar arm kinematics block

// joint angle channel
interface pafk_in_if import pafk_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle_0;
    logic [ANGLE_BITS-1:0] angle_1;
    logic [ANGLE_BITS-1:0] angle_2;
    logic [ANGLE_BITS-1:0] angle_3;
    logic [ANGLE_BITS-1:0] angle_4;
    logic [ANGLE_BITS-1:0] angle_5;

    modport source (
        output valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
        input  ready
    );
    modport sink (
        input  valid, angle_0, angle_1, angle_2, angle_3, angle_4, angle_5,
        output ready
    );
endinterface

// end-effector position channel
interface pafk_out_if import pafk_pkg::*; ();
    logic valid;
    logic ready;
    t_pos pos_x;
    t_pos pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink (input valid, pos_x, pos_y, output ready);
endinterface

// hold mask write channel
interface pafk_cfg_if import pafk_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HOLD_BITS-1:0] hold_mask;

    modport source (output valid, hold_mask, input ready);
    modport sink (input valid, hold_mask, output ready);
endinterface

FILE: hdl/planar_arm_forward_kinematics.sv
// Top level: planar six-link arm forward kinematics, one pose per cycle while the skid entry is empty
//
// Channel   Direction  Handshake     Payload
// i_angles  in         valid/ready   angle_0 .. angle_5, ANGLE_BITS each, unsigned turns
// i_cfg     in         valid/ready   hold_mask, 6 bits, ready always high
// o_pos     out        valid/ready   pos_x, pos_y, signed Q3.FRAC_BITS
//
// Sustained rate one pose per cycle while the skid entry is empty. On its way to o_pos
// a result passes 1 prefix-sum stage, 4 + 3 * COS_TERMS lane stages, 3 merge stages
// and the output register; the cosine series, three stages for each of its six steps,
// sets the depth. Reset clears the hold mask, the stage valid bits and the output and
// skid flags. A stalled output holds its result and one more lands in the skid entry;
// only while the skid entry is full does i_angles drop ready and the pipeline freeze.
module planar_arm_forward_kinematics import pafk_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pafk_in_if.sink    i_angles,
    pafk_cfg_if.sink   i_cfg,
    pafk_out_if.source o_pos
);

    localparam int PIPE_LAT = 1 + LANE_LAT + MERGE_LAT;

    logic [ANGLE_BITS-1:0] angle_in [JOINTS];
    logic [ANGLE_BITS-1:0] n_cum [JOINTS];
    logic [ANGLE_BITS-1:0] cum_acc;
    t_sincos               lane_sc [JOINTS];
    t_position             merge_pos;

    logic [HOLD_BITS-1:0]  r_hold_mask;
    logic [PIPE_LAT-1:0]   r_vld;
    logic [ANGLE_BITS-1:0] r_cum [JOINTS];
    logic                  r_out_valid;
    logic                  r_skid_valid;
    t_position             r_out;
    t_position             r_skid;

    logic en;
    logic out_free;
    logic pipe_done;
    logic n_out_valid;
    logic n_skid_valid;
    logic ld_out_pipe;
    logic ld_out_skid;
    logic ld_skid;

    // pipeline advances unless the skid entry is occupied
    assign en             = !r_skid_valid;
    assign i_angles.ready = en;
    assign i_cfg.ready    = 1'b1;

    // hold mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_mask <= '0;
        end else if (i_cfg.valid) begin
            r_hold_mask <= i_cfg.hold_mask;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_angles.valid};
        end
    end

    assign angle_in[0] = i_angles.angle_0;
    assign angle_in[1] = i_angles.angle_1;
    assign angle_in[2] = i_angles.angle_2;
    assign angle_in[3] = i_angles.angle_3;
    assign angle_in[4] = i_angles.angle_4;
    assign angle_in[5] = i_angles.angle_5;

    // cumulative joint angles, held joints taken as zero, wrap modulo one turn
    always_comb begin
        cum_acc = '0;
        for (int k = 0; k < JOINTS; k++) begin
            cum_acc  = cum_acc + (r_hold_mask[k] ? '0 : angle_in[k]);
            n_cum[k] = cum_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cum <= n_cum;
        end
    end

    // one lane per joint
    for (genvar k = 0; k < JOINTS; k++) begin : g_lane
        pafk_lane #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_cum (r_cum[k]),
            .o_sc  (lane_sc[k])
        );
    end

    pafk_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_sc  (lane_sc),
        .o_pos (merge_pos)
    );

    // output register with one skid entry
    always_comb begin
        out_free     = !r_out_valid || o_pos.ready;
        pipe_done    = r_vld[PIPE_LAT-1] && en;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        ld_out_pipe  = 1'b0;
        ld_out_skid  = 1'b0;
        ld_skid      = 1'b0;
        priority if (out_free && r_skid_valid) begin
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
            ld_out_skid  = 1'b1;
        end else if (out_free && pipe_done) begin
            n_out_valid = 1'b1;
            ld_out_pipe = 1'b1;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else if (pipe_done) begin
            n_skid_valid = 1'b1;
            ld_skid      = 1'b1;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out_skid) begin
            r_out <= r_skid;
        end else if (ld_out_pipe) begin
            r_out <= merge_pos;
        end
        if (ld_skid) begin
            r_skid <= merge_pos;
        end
    end

    assign o_pos.valid = r_out_valid;
    assign o_pos.pos_x = r_out.x;
    assign o_pos.pos_y = r_out.y;

`include "assert_macros.svh"

    // skid entry only ever sits behind a held output
    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid, "skid full with output empty")

    // skid fills only when the output was blocked
    `ASSERT_IMPLIES(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_valid), $past(r_out_valid && !o_pos.ready), "skid filled without stall")

    // output turns valid only from a finished pipeline item
    `ASSERT_IMPLIES(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_vld[PIPE_LAT-1]), "result without pipeline item")

endmodule

FILE: hdl/pafk_nest_step.sv
// One step of the nested Horner series: t' = 1 - floor(floor(r2 * t) / d), three stages
module pafk_nest_step import pafk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_q30                  i_r2,
    input  t_unit                 i_t,
    input  logic [DIV_BITS-1:0]   i_div,
    input  logic [RECIP_BITS-1:0] i_recip,
    output t_unit                 o_t
);

    localparam int PA_BITS = 2 * Q_BITS + 1;
    localparam int PB_BITS = Q_BITS + RECIP_BITS;
    localparam int PC_BITS = Q_BITS + DIV_BITS;

    logic [PA_BITS-1:0] prod_a;
    logic [PB_BITS-1:0] prod_b;
    logic [PC_BITS-1:0] quo_d;
    logic [PC_BITS-1:0] quo_lim;
    logic               quo_inc;

    t_q30  r_q_a;
    t_q30  r_q_b;
    t_q30  r_quo;
    t_unit r_t;

    // truncated Q30 product
    assign prod_a = PA_BITS'(i_r2) * PA_BITS'(i_t);

    // quotient estimate by reciprocal, low by at most one
    assign prod_b = PB_BITS'(r_q_a) * PB_BITS'(i_recip);

    // bump the estimate when the remainder still reaches the divisor
    assign quo_d   = PC_BITS'(r_quo) * PC_BITS'(i_div);
    assign quo_lim = quo_d + PC_BITS'(i_div);
    assign quo_inc = (PC_BITS'(r_q_b) >= quo_lim);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_a <= prod_a[2*Q_BITS-1:Q_BITS];
            r_q_b <= r_q_a;
            r_quo <= prod_b[PB_BITS-1:RECIP_BITS];
            r_t   <= Q30_ONE - ((Q_BITS + 1)'(r_quo) + (Q_BITS + 1)'(quo_inc));
        end
    end

    assign o_t = r_t;

endmodule

FILE: hdl/pafk_lane.sv
// Sine and cosine of one cumulative joint angle, octant reduced, fully pipelined
module pafk_lane import pafk_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_cum,
    output t_sincos               o_sc
);

    localparam int SIDE_LEN  = 3 * SIN_TERMS;
    localparam int SR_STAGES = 3 * (COS_TERMS - SIN_TERMS);
    localparam int PR_BITS   = TURN_BITS + Q_BITS + 1;
    localparam int PQ_BITS   = 2 * Q_BITS;
    localparam int PS_BITS   = 2 * Q_BITS + 1;

    typedef struct packed {
        logic [2:0] oct;
        t_q30       r;
        t_q30       r2;
    } t_side;

    logic [TURN_BITS-1:0] phi;
    logic [2:0]           oct_in;
    logic [OCT_BITS:0]    f_ext;
    logic [OCT_BITS:0]    a_in;
    logic [PR_BITS-1:0]   prod_r;
    logic [PQ_BITS-1:0]   prod_r2;
    logic [PS_BITS-1:0]   prod_s;

    logic [OCT_BITS:0] r_a;
    logic [2:0]        r_oct_a;
    t_q30              r_r;
    logic [2:0]        r_oct_r;
    t_q30              r_r2;
    t_q30              r_r_q;
    logic [2:0]        r_oct_q;
    t_side             r_side [SIDE_LEN];
    t_q30              r_sr_dly [SR_STAGES];
    logic [2:0]        r_oct_dly [SR_STAGES];
    t_sincos           r_sc;

    t_q30  r2_tap [COS_TERMS];
    t_unit sin_t [SIN_TERMS+1];
    t_unit cos_t [COS_TERMS+1];

    logic       oct_swap;
    t_q30       sr_fin;
    t_unit      cr_fin;
    logic [2:0] oct_fin;
    t_unit      s_mag;
    t_unit      c_mag;
    t_trig      s_ext;
    t_trig      c_ext;
    t_sincos    n_sc;

    // fold the angle into the first octant
    assign phi    = {i_cum, {(TURN_BITS - ANGLE_BITS){1'b0}}};
    assign oct_in = phi[TURN_BITS-1:OCT_BITS];
    assign f_ext  = {1'b0, phi[OCT_BITS-1:0]};
    assign a_in   = oct_in[0] ? (((OCT_BITS + 1)'(1) << OCT_BITS) - f_ext) : f_ext;

    // radians in Q30 and their square
    assign prod_r  = PR_BITS'(r_a) * PR_BITS'(PI_Q31);
    assign prod_r2 = PQ_BITS'(r_r) * PQ_BITS'(r_r);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= a_in;
            r_oct_a <= oct_in;
            r_r     <= prod_r[TURN_BITS+Q_BITS-1:TURN_BITS];
            r_oct_r <= r_oct_a;
            r_r2    <= prod_r2[2*Q_BITS-1:Q_BITS];
            r_r_q   <= r_r;
            r_oct_q <= r_oct_r;
        end
    end

    // side line carries octant, r and r2 alongside the series steps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= '{oct: r_oct_q, r: r_r_q, r2: r_r2};
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // r2 seen by each series step, three stages apart
    assign r2_tap[0] = r_r2;
    for (genvar j = 1; j < COS_TERMS; j++) begin : g_tap
        assign r2_tap[j] = r_side[3*j-1].r2;
    end

    // sine series, innermost divisor first
    assign sin_t[0] = Q30_ONE;
    for (genvar j = 0; j < SIN_TERMS; j++) begin : g_sin
        pafk_nest_step u_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_r2    (r2_tap[j]),
            .i_t     (sin_t[j]),
            .i_div   (SIN_DIV[SIN_TERMS-1-j]),
            .i_recip (SIN_RECIP[SIN_TERMS-1-j]),
            .o_t     (sin_t[j+1])
        );
    end

    // cosine series, innermost divisor first
    assign cos_t[0] = Q30_ONE;
    for (genvar j = 0; j < COS_TERMS; j++) begin : g_cos
        pafk_nest_step u_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_r2    (r2_tap[j]),
            .i_t     (cos_t[j]),
            .i_div   (COS_DIV[COS_TERMS-1-j]),
            .i_recip (COS_RECIP[COS_TERMS-1-j]),
            .o_t     (cos_t[j+1])
        );
    end

    // sine = r * series, then wait for the longer cosine chain
    assign prod_s = PS_BITS'(r_side[SIDE_LEN-1].r) * PS_BITS'(sin_t[SIN_TERMS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr_dly[0]  <= prod_s[2*Q_BITS-1:Q_BITS];
            r_oct_dly[0] <= r_side[SIDE_LEN-1].oct;
            for (int k = 1; k < SR_STAGES; k++) begin
                r_sr_dly[k]  <= r_sr_dly[k-1];
                r_oct_dly[k] <= r_oct_dly[k-1];
            end
        end
    end

    // map the first-octant pair back onto the full circle
    assign sr_fin   = r_sr_dly[SR_STAGES-1];
    assign oct_fin  = r_oct_dly[SR_STAGES-1];
    assign cr_fin   = cos_t[COS_TERMS];
    assign oct_swap = oct_fin[0] ^ oct_fin[1];

    always_comb begin
        s_mag  = oct_swap ? cr_fin : {1'b0, sr_fin};
        c_mag  = oct_swap ? {1'b0, sr_fin} : cr_fin;
        s_ext  = $signed(TRIG_BITS'(s_mag));
        c_ext  = $signed(TRIG_BITS'(c_mag));
        n_sc.s = oct_fin[2] ? -s_ext : s_ext;
        n_sc.c = (oct_fin[1] ^ oct_fin[2]) ? -c_ext : c_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc <= n_sc;
        end
    end

    assign o_sc = r_sc;

endmodule

FILE: hdl/pafk_merge.sv
// Sum the six lane results, round to the output format and clamp
module pafk_merge import pafk_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_sincos   i_sc [JOINTS],
    output t_position o_pos
);

    localparam int PAIRS     = JOINTS / 2;
    localparam int PAIR_BITS = TRIG_BITS + 1;
    localparam int SUM_BITS  = TRIG_BITS + 2;
    localparam int SHIFT     = Q_BITS - FRAC_BITS;
    localparam logic signed [SUM_BITS-1:0] HALF    = SUM_BITS'(1) <<< (SHIFT - 1);
    localparam logic signed [SUM_BITS-1:0] POS_MAX = SUM_BITS'((1 << (POS_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] POS_MIN = -SUM_BITS'(1 << (POS_BITS - 1));

    logic signed [PAIR_BITS-1:0] r_px [PAIRS];
    logic signed [PAIR_BITS-1:0] r_py [PAIRS];
    logic signed [SUM_BITS-1:0]  r_sx;
    logic signed [SUM_BITS-1:0]  r_sy;
    t_position                   r_pos;

    logic signed [SUM_BITS-1:0] n_sx;
    logic signed [SUM_BITS-1:0] n_sy;
    logic signed [SUM_BITS-1:0] rnd_x;
    logic signed [SUM_BITS-1:0] rnd_y;
    t_position                  n_pos;

    // first level: neighbouring lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < PAIRS; p++) begin
                r_px[p] <= PAIR_BITS'(i_sc[2*p].c) + PAIR_BITS'(i_sc[2*p+1].c);
                r_py[p] <= PAIR_BITS'(i_sc[2*p].s) + PAIR_BITS'(i_sc[2*p+1].s);
            end
        end
    end

    // second level: total over the pairs
    always_comb begin
        n_sx = '0;
        n_sy = '0;
        for (int p = 0; p < PAIRS; p++) begin
            n_sx = n_sx + SUM_BITS'(r_px[p]);
            n_sy = n_sy + SUM_BITS'(r_py[p]);
        end
    end

    // round half up, then clamp to the port range
    always_comb begin
        rnd_x = (r_sx + HALF) >>> SHIFT;
        rnd_y = (r_sy + HALF) >>> SHIFT;
        priority if (rnd_x > POS_MAX) begin
            n_pos.x = t_pos'(POS_MAX);
        end else if (rnd_x < POS_MIN) begin
            n_pos.x = t_pos'(POS_MIN);
        end else begin
            n_pos.x = t_pos'(rnd_x);
        end
        priority if (rnd_y > POS_MAX) begin
            n_pos.y = t_pos'(POS_MAX);
        end else if (rnd_y < POS_MIN) begin
            n_pos.y = t_pos'(POS_MIN);
        end else begin
            n_pos.y = t_pos'(rnd_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

FILE: dv/planar_arm_forward_kinematics_test.sv
// Testbench of the planar arm kinematics block: directed and random poses against a local predictor
`timescale 1ns / 100ps

module planar_arm_forward_kinematics_test;
    import pafk_pkg::*;

    localparam int ANGLE_W      = ANGLE_BITS_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int RANDOM_POSES = 1150;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 30;
    localparam int REPORT_MAX   = 10;

    localparam longint unsigned UNIT_Q30    = 64'd1 << 30;
    localparam longint unsigned PI_TURN_Q31 = 64'h1_921F_B544;
    localparam longint unsigned SIN_DIVISORS [5] = '{6, 20, 42, 72, 110};
    localparam longint unsigned COS_DIVISORS [6] = '{2, 12, 30, 56, 90, 132};

    typedef logic [JOINTS-1:0][ANGLE_W-1:0] t_pose;

    logic clk;
    logic rst_n;

    pafk_in_if #(.ANGLE_BITS(ANGLE_W)) angles_if ();
    pafk_cfg_if                        cfg_if ();
    pafk_out_if                        pos_if ();

    planar_arm_forward_kinematics DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_angles (angles_if),
        .i_cfg    (cfg_if),
        .o_pos    (pos_if)
    );

    // predictor state and bookkeeping
    logic [HOLD_BITS-1:0] hold_mask_model;
    t_position            expected_positions [$];
    int                   idle_pct;
    int                   stall_pct;
    int                   poses_sent;
    int                   positions_checked;
    int                   mask_writes;
    int                   mismatches;

    // clock generation
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // nested Horner series in unsigned Q30, floor at every step
    function automatic longint unsigned horner_q30(longint unsigned r2, bit cosine);
        longint unsigned t;
        longint unsigned d;
        t = UNIT_Q30;
        for (int i = (cosine ? 5 : 4); i >= 0; i--) begin
            d = cosine ? COS_DIVISORS[i] : SIN_DIVISORS[i];
            t = UNIT_Q30 - (((r2 * t) >> 30) / d);
        end
        return t;
    endfunction

    // signed Q30 sine and cosine of a 32-bit turn fraction, by octant folding
    function automatic void turn_sincos(input logic [31:0] phi, output longint s,
                                        output longint c);
        logic [2:0]      oct;
        longint unsigned a;
        longint unsigned r;
        longint unsigned r2;
        longint          sr;
        longint          cr;
        oct = phi[31:29];
        a   = oct[0] ? ((64'd1 << 29) - 64'(phi[28:0])) : 64'(phi[28:0]);
        r   = (a * PI_TURN_Q31) >> 32;
        r2  = (r * r) >> 30;
        sr  = longint'((r * horner_q30(r2, 1'b0)) >> 30);
        cr  = longint'(horner_q30(r2, 1'b1));
        case (oct)
            3'd0: begin s =  sr; c =  cr; end
            3'd1: begin s =  cr; c =  sr; end
            3'd2: begin s =  cr; c = -sr; end
            3'd3: begin s =  sr; c = -cr; end
            3'd4: begin s = -sr; c = -cr; end
            3'd5: begin s = -cr; c = -sr; end
            3'd6: begin s = -cr; c =  sr; end
            default: begin s = -sr; c =  cr; end
        endcase
    endfunction

    // round a Q30 sum half up to Q3.FRAC and clamp to the port width
    function automatic t_pos round_position(longint sum);
        longint unsigned biased;
        longint          v;
        biased = longint'(sum + (longint'(JOINTS) <<< 30));
        v = longint'((biased + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
        v = v - (longint'(JOINTS) <<< FRAC);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return t_pos'(v);
    endfunction

    // end-effector position of a pose under the current hold mask
    function automatic t_position arm_position(t_pose pose, logic [HOLD_BITS-1:0] mask);
        logic [31:0]         cum;
        logic [ANGLE_W-1:0]  ang;
        longint              sum_x;
        longint              sum_y;
        longint              s;
        longint              c;
        t_position           result;
        cum   = '0;
        sum_x = 0;
        sum_y = 0;
        for (int k = 0; k < JOINTS; k++) begin
            ang = mask[k] ? '0 : pose[k];
            cum = cum + (32'(ang) << (32 - ANGLE_W));
            turn_sincos(cum, s, c);
            sum_x += c;
            sum_y += s;
        end
        result.x = round_position(sum_x);
        result.y = round_position(sum_y);
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // stall the position sink at random
    always @(negedge clk) begin
        pos_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // offer one pose, hold it until transfer, then record its position
    task automatic send_pose(t_pose pose);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            angles_if.valid <= 1'b0;
            @(negedge clk);
        end
        angles_if.valid   <= 1'b1;
        angles_if.angle_0 <= pose[0];
        angles_if.angle_1 <= pose[1];
        angles_if.angle_2 <= pose[2];
        angles_if.angle_3 <= pose[3];
        angles_if.angle_4 <= pose[4];
        angles_if.angle_5 <= pose[5];
        do
            @(posedge clk);
        while (!angles_if.ready);
        expected_positions.push_back(arm_position(pose, hold_mask_model));
        poses_sent++;
    endtask

    // drop valid and wait until every pending position has come out
    task automatic drain_positions();
        @(negedge clk);
        angles_if.valid <= 1'b0;
        while (expected_positions.size() > 0)
            @(posedge clk);
    endtask

    // write the hold mask while the block is idle
    task automatic write_hold_mask(logic [HOLD_BITS-1:0] mask);
        drain_positions();
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.hold_mask <= mask;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        hold_mask_model = mask;
        mask_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_pose joint0_pose(logic [ANGLE_W-1:0] value);
        t_pose pose;
        pose    = '0;
        pose[0] = value;
        return pose;
    endfunction

    // angle biased towards octant boundaries and the range ends
    function automatic logic [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] value;
        case ($urandom_range(9))
            0: value = ANGLE_W'(($urandom_range(7) << (ANGLE_W - 3))
                                + $urandom_range(8) - 4);
            1: value = '0;
            2: value = '1;
            default: value = ANGLE_W'($urandom_range(65535));
        endcase
        return value;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        t_position want;
        if (rst_n && pos_if.valid && pos_if.ready) begin
            if (expected_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: position x=%0d y=%0d with none pending",
                             $realtime, pos_if.pos_x, pos_if.pos_y);
            end else begin
                want = expected_positions.pop_front();
                positions_checked++;
                if (pos_if.pos_x !== want.x || pos_if.pos_y !== want.y) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: position mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 $realtime, want.x, want.y, pos_if.pos_x, pos_if.pos_y);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset value of the mask: straight arm along each axis and the range ends
    task automatic test_after_reset();
        send_pose('0);
        send_pose('1);
        send_pose(joint0_pose(16'h4000));
        send_pose(joint0_pose(16'h8000));
        send_pose(joint0_pose(16'hC000));
    endtask

    // every octant of the cumulative angle, and both sides of one boundary
    task automatic test_octants();
        for (int k = 0; k < 8; k++)
            send_pose(joint0_pose(ANGLE_W'(k << (ANGLE_W - 3))));
        send_pose(joint0_pose(16'h1FFF));
        send_pose(joint0_pose(16'h2001));
    endtask

    // hold mask: all joints, first, last and alternating joints held
    task automatic test_hold_mask();
        logic [HOLD_BITS-1:0] masks [4];
        t_pose                pose;
        masks = '{6'h3F, 6'h01, 6'h20, 6'h2A};
        foreach (masks[m]) begin
            write_hold_mask(masks[m]);
            send_pose('1);
            for (int k = 0; k < JOINTS; k++)
                pose[k] = random_angle();
            send_pose(pose);
        end
    endtask

    // random poses over several mask settings, with a stretch free of idles and stalls and a pause
    task automatic test_random();
        t_pose pose;
        for (int p = 0; p < PHASES; p++) begin
            write_hold_mask((p == 0 || p == PHASES - 1) ? '0
                            : HOLD_BITS'($urandom_range(63)));
            for (int n = 0; n < RANDOM_POSES / PHASES; n++) begin
                idle_pct  = (p == 1 && n < 150) ? 0 : 11;
                stall_pct = idle_pct;
                if (p == 2 && n == 100)
                    drain_positions();
                for (int k = 0; k < JOINTS; k++)
                    pose[k] = random_angle();
                send_pose(pose);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n             = 1'b0;
        angles_if.valid   = 1'b0;
        angles_if.angle_0 = '0;
        angles_if.angle_1 = '0;
        angles_if.angle_2 = '0;
        angles_if.angle_3 = '0;
        angles_if.angle_4 = '0;
        angles_if.angle_5 = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.hold_mask  = '0;
        pos_if.ready      = 1'b0;
        clk               = 1'b0;
        hold_mask_model   = '0;
        idle_pct          = 11;
        stall_pct         = 11;
        poses_sent        = 0;
        positions_checked = 0;
        mask_writes       = 0;
        mismatches        = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_octants();
        test_hold_mask();
        test_random();

        drain_positions();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d joint poses under %0d hold mask writes; %0d positions checked.",
                 poses_sent, mask_writes, positions_checked);
        $display("Mismatching or unexpected positions: %0d", mismatches);
        if (mismatches == 0 && expected_positions.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Timed out with %0d positions pending", expected_positions.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
